// File: src/spectrum_to_xyz_convert_macros.svh
// Assertion macros used by the checker file.
`ifndef SPECTRUM_TO_XYZ_CONVERT_MACROS_SVH
`define SPECTRUM_TO_XYZ_CONVERT_MACROS_SVH

// Check a property outside reset.
`define S2X_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every edge, reset included.
`define S2X_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/s2x_pkg.sv
package s2x_pkg;

  // Field widths
  localparam int unsigned SAMPLES    = 4;
  localparam int unsigned SPEC_W     = 32;
  localparam int unsigned WL_W       = 16;
  localparam int unsigned TIDX_W     = 9;
  localparam int unsigned TSEL_W     = 2;
  localparam int unsigned TWORD_W    = 18;
  localparam int unsigned LAMBDA_W   = 10;
  localparam int unsigned INV_W      = 24;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned NUM_W      = 11;  // rounded wavelength in nm, up to 1024
  localparam int unsigned KIDX_W     = 12;  // signed table index before range check

  // Stream packing
  localparam int unsigned WL_LSB      = SAMPLES * SPEC_W;
  localparam int unsigned TIDX_LSB    = WL_LSB + SAMPLES * WL_W;
  localparam int unsigned TSEL_LSB    = TIDX_LSB + TIDX_W;
  localparam int unsigned TWORD_LSB   = TSEL_LSB + TSEL_W;
  localparam int unsigned IN_FIELDS_W = TWORD_LSB + TWORD_W;
  localparam int unsigned IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = 3 * VAL_W;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = INV_W;
  localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA_MAX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_Y_INTEG = 2'd2;

  localparam logic [LAMBDA_W-1:0] LAMBDA_MIN_RST = 10'd360;
  localparam logic [LAMBDA_W-1:0] LAMBDA_MAX_RST = 10'd830;
  localparam logic [INV_W-1:0]    INV_Y_RST      = 24'd157002;

  // Table selection on load
  localparam logic [TSEL_W-1:0] TSEL_X = 2'd0;
  localparam logic [TSEL_W-1:0] TSEL_Y = 2'd1;
  localparam logic [TSEL_W-1:0] TSEL_Z = 2'd2;

  typedef enum logic {
    CMD_CONVERT = 1'b0,
    CMD_LOAD    = 1'b1
  } command_t;

  typedef logic [SAMPLES-1:0][SPEC_W-1:0]  spec_lanes_t;
  typedef logic [SAMPLES-1:0][TWORD_W-1:0] word_lanes_t;

  // Table write request
  typedef struct packed {
    logic               en;
    logic [TIDX_W-1:0]  index;
    logic [TWORD_W-1:0] word;
  } tbl_wr_t;

  // Scaling shared by the three channels
  typedef struct packed {
    logic [LAMBDA_W-1:0] range;
    logic [INV_W-1:0]    inv;
    logic                blank;
  } scale_t;

endpackage

// File: src/s2x_ram.sv
module s2x_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/s2x_table.sv
module s2x_table
  import s2x_pkg::*;
#(
  parameter int unsigned DEPTH = 512,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                           clk,
  input  tbl_wr_t                        wr,
  input  logic                           rd_en,
  input  logic [SAMPLES-1:0][ADDR_W-1:0] rd_addr,
  output word_lanes_t                    rd_data
);

  logic [ADDR_W-1:0] wr_addr;

  assign wr_addr = ADDR_W'(wr.index);

  // One copy per sample lane; a load writes all copies alike
  for (genvar i = 0; i < SAMPLES; i++) begin : g_lane
    s2x_ram #(
      .WIDTH (TWORD_W),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk     (clk),
      .wr_en   (wr.en),
      .wr_addr (wr_addr),
      .wr_data (wr.word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr[i]),
      .rd_data (rd_data[i])
    );
  end

endmodule

// File: src/s2x_channel.sv
module s2x_channel
  import s2x_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  word_lanes_t        weight,
  input  logic [SAMPLES-1:0] hit,
  input  spec_lanes_t        spec,
  input  scale_t             scale,
  output logic [VAL_W-1:0]   result
);

  localparam int unsigned PROD_W = SPEC_W + TWORD_W;   // 50
  localparam int unsigned SUM_W  = PROD_W + 2;         // 52
  localparam int unsigned A_W    = SUM_W + LAMBDA_W;   // 62
  localparam int unsigned PLO_W  = 32 + INV_W;         // 56
  localparam int unsigned PHI_W  = (A_W - 32) + INV_W; // 54
  localparam int unsigned RND_W  = PLO_W + 1;
  localparam int unsigned HI_W   = PHI_W + 1;
  localparam int unsigned SCL_W  = HI_W - 10;
  localparam logic [RND_W-1:0] RND_ADD = RND_W'(1) << 41;

  word_lanes_t               weight_eff;
  logic [SAMPLES-1:0][PROD_W-1:0] prod_r;
  logic [SUM_W-1:0]          sum_r;
  logic [A_W-1:0]            a_r;
  logic [PLO_W-1:0]          plo_r;
  logic [PHI_W-1:0]          phi_r;
  logic [RND_W-1:0]          rnd;
  logic [HI_W-1:0]           hi;
  logic [SCL_W-1:0]          scaled;

  // Drop weights of samples that fall outside the table
  always_comb begin
    for (int i = 0; i < SAMPLES; i++) begin
      weight_eff[i] = hit[i] ? weight[i] : '0;
    end
  end

  // Products, sum, range scale, split reciprocal multiply
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < SAMPLES; i++) begin
        prod_r[i] <= weight_eff[i] * spec[i];
      end
      sum_r <= SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(prod_r[2])
             + SUM_W'(prod_r[3]);
      a_r   <= sum_r * scale.range;
      plo_r <= a_r[31:0] * scale.inv;
      phi_r <= a_r[A_W-1:32] * scale.inv;
    end
  end

  // Recombine, round half up, drop 42 fraction bits and saturate; zero when blanked
  always_comb begin
    rnd    = {1'b0, plo_r} + RND_ADD;
    hi     = {1'b0, phi_r} + HI_W'(rnd[RND_W-1:32]);
    scaled = hi[HI_W-1:10];
    if (scale.blank) begin
      result = '0;
    end else if (|scaled[SCL_W-1:VAL_W]) begin
      result = '1;
    end else begin
      result = scaled[VAL_W-1:0];
    end
  end

endmodule

// File: src/spectrum_to_xyz_convert.sv
// Spectral to CIE XYZ converter. A transaction with in_tuser high loads one word of the
// X, Y or Z matching table; one with in_tuser low converts four spectral samples into an
// XYZ triple, presented on the output. One transaction is taken every cycle while
// in_tready is high. The pipeline registers the lookup addresses, then holds the table
// read, the four products, their sum, the range scale, a reciprocal multiply split in
// two halves, and the output register.
// Each table is held four times, one copy per sample, so all lookups are made in the same cycle.
// A result waiting at the output does not stop the input: a skid register takes one more,
// and in_tready drops only while both hold a result. A load is seen by any conversion
// accepted after it. Tables are undefined until written; the user must write configuration
// only while no transaction is in flight, as the block does not enforce it.
module spectrum_to_xyz_convert
  import s2x_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 512
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // spectrum_0..3, wavelength_0..3, table_index, table_select, table_word, zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // command
  input  logic                   in_tuser,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // x_value, y_value, z_value
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int unsigned TAB_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Configuration registers
  logic [LAMBDA_W-1:0] lambda_min_r;
  logic [LAMBDA_W-1:0] lambda_max_r;
  logic [INV_W-1:0]    inv_y_r;
  scale_t              scale;

  // Pipeline control
  logic pipe_en;
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, s5_valid_r, s6_valid_r;

  // Stage 1: lookup addresses and the load request
  logic [SAMPLES-1:0][TAB_AW-1:0] lane_addr;
  logic [SAMPLES-1:0]             lane_hit;
  logic [SAMPLES-1:0][TAB_AW-1:0] s1_addr_r;
  logic [SAMPLES-1:0]             s1_hit_r;
  spec_lanes_t                    s1_spec_r;
  command_t                       s1_cmd_r;
  logic [TIDX_W-1:0]              s1_tidx_r;
  logic [TSEL_W-1:0]              s1_tsel_r;
  logic [TWORD_W-1:0]             s1_tword_r;

  // Stage 2: table data arrives
  spec_lanes_t        s2_spec_r;
  logic [SAMPLES-1:0] s2_hit_r;
  logic               load_ok;
  tbl_wr_t            wr_x, wr_y, wr_z;
  word_lanes_t        w_x, w_y, w_z;

  // Results and output stage
  logic [VAL_W-1:0]       res_x, res_y, res_z;
  logic [OUT_TDATA_W-1:0] res_data;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   skid_valid_r, skid_valid_nxt;
  logic [OUT_TDATA_W-1:0] skid_data_r, skid_data_nxt;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lambda_min_r <= LAMBDA_MIN_RST;
      lambda_max_r <= LAMBDA_MAX_RST;
      inv_y_r      <= INV_Y_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_LAMBDA_MIN:  lambda_min_r <= cfg_wdata[LAMBDA_W-1:0];
        CFG_LAMBDA_MAX:  lambda_max_r <= cfg_wdata[LAMBDA_W-1:0];
        CFG_INV_Y_INTEG: inv_y_r      <= cfg_wdata[INV_W-1:0];
        default: ;
      endcase
    end
  end

  assign scale.range = lambda_max_r - lambda_min_r;
  assign scale.inv   = inv_y_r;
  assign scale.blank = (lambda_max_r <= lambda_min_r);

  // Advance the whole pipeline while the skid register is free
  assign pipe_en   = !skid_valid_r;
  assign in_tready = pipe_en;

  // Round each wavelength to nm and offset it into the table
  always_comb begin
    logic [WL_W:0]              wl_sum;
    logic [NUM_W-1:0]           nm;
    logic signed [KIDX_W-1:0]   k;
    for (int i = 0; i < SAMPLES; i++) begin
      wl_sum       = {1'b0, in_tdata[WL_LSB + WL_W*i +: WL_W]} + (WL_W+1)'(32);
      nm           = wl_sum[WL_W:6];
      k            = $signed({1'b0, nm}) - $signed({2'b0, lambda_min_r});
      lane_hit[i]  = (k >= 0) && (int'(k) < TABLE_DEPTH);
      lane_addr[i] = TAB_AW'($unsigned(k));
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_r <= in_tvalid;
      s2_valid_r <= s1_valid_r && (s1_cmd_r == CMD_CONVERT);
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
      s6_valid_r <= s5_valid_r;
    end
  end

  // Stage 1 and stage 2 payload
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_addr_r  <= lane_addr;
      s1_hit_r   <= lane_hit;
      s1_spec_r  <= in_tdata[WL_LSB-1:0];
      s1_cmd_r   <= command_t'(in_tuser);
      s1_tidx_r  <= in_tdata[TIDX_LSB +: TIDX_W];
      s1_tsel_r  <= in_tdata[TSEL_LSB +: TSEL_W];
      s1_tword_r <= in_tdata[TWORD_LSB +: TWORD_W];
      s2_spec_r  <= s1_spec_r;
      s2_hit_r   <= s1_hit_r;
    end
  end

  // Issue a load as the item leaves stage 1; indexes past the depth are ignored
  assign load_ok = pipe_en && s1_valid_r && (s1_cmd_r == CMD_LOAD)
                && (int'(s1_tidx_r) < TABLE_DEPTH);

  assign wr_x = '{en: load_ok && (s1_tsel_r == TSEL_X), index: s1_tidx_r, word: s1_tword_r};
  assign wr_y = '{en: load_ok && (s1_tsel_r == TSEL_Y), index: s1_tidx_r, word: s1_tword_r};
  assign wr_z = '{en: load_ok && (s1_tsel_r == TSEL_Z), index: s1_tidx_r, word: s1_tword_r};

  s2x_table #(.DEPTH(TABLE_DEPTH)) u_table_x (
    .clk (clk), .wr (wr_x), .rd_en (pipe_en), .rd_addr (s1_addr_r), .rd_data (w_x)
  );
  s2x_table #(.DEPTH(TABLE_DEPTH)) u_table_y (
    .clk (clk), .wr (wr_y), .rd_en (pipe_en), .rd_addr (s1_addr_r), .rd_data (w_y)
  );
  s2x_table #(.DEPTH(TABLE_DEPTH)) u_table_z (
    .clk (clk), .wr (wr_z), .rd_en (pipe_en), .rd_addr (s1_addr_r), .rd_data (w_z)
  );

  // Stages 3 to 6 per colour channel
  s2x_channel u_chan_x (
    .clk (clk), .en (pipe_en), .weight (w_x), .hit (s2_hit_r), .spec (s2_spec_r),
    .scale (scale), .result (res_x)
  );
  s2x_channel u_chan_y (
    .clk (clk), .en (pipe_en), .weight (w_y), .hit (s2_hit_r), .spec (s2_spec_r),
    .scale (scale), .result (res_y)
  );
  s2x_channel u_chan_z (
    .clk (clk), .en (pipe_en), .weight (w_z), .hit (s2_hit_r), .spec (s2_spec_r),
    .scale (scale), .result (res_z)
  );

  assign res_data = {res_z, res_y, res_x};

  // Output register with skid: drain first, then place the leaving item
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = skid_valid_r;
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end
    if (pipe_en && s6_valid_r) begin
      if (!out_valid_nxt) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res_data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: src/s2x_checker.sv
`include "spectrum_to_xyz_convert_macros.svh"

module s2x_checker
  import s2x_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tvalid,
  input logic                   out_tready
);

  // Reset empties the output side and opens the input
  `S2X_ASSERT_ALWAYS(a_reset_state, !rst_n |=> !out_tvalid && in_tready, "reset state wrong")

  // A result not taken stays put
  `S2X_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata),
              "result changed under stall")

  // Back-pressure only while a result waits
  `S2X_ASSERT(a_stall_has_result, !in_tready |-> out_tvalid,
              "input stalled with no result waiting")

  // Ready drops only after a result was refused
  `S2X_ASSERT(a_stall_cause, $fell(in_tready) |-> $past(out_tvalid && !out_tready),
              "input stalled without output stall")

endmodule

bind spectrum_to_xyz_convert s2x_checker u_checker (.*);
